### hdl/plc_pkg.sv
// Shared types and codes for the piecewise-linear curve lookup.
package plc_pkg;

    localparam int DATA_W = 16;
    localparam int DIFF_W = 17;
    localparam int PROD_W = 34;
    localparam int DIV_W  = 33;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    localparam logic [2:0] ST_INTERP = 3'd0;
    localparam logic [2:0] ST_BELOW  = 3'd1;
    localparam logic [2:0] ST_ABOVE  = 3'd2;
    localparam logic [2:0] ST_FEW    = 3'd3;
    localparam logic [2:0] ST_NOSEG  = 3'd4;

    localparam logic [1:0] EM_ZERO = 2'd0;
    localparam logic [1:0] EM_RDY  = 2'd1;
    localparam logic [1:0] EM_YL   = 2'd2;
    localparam logic [1:0] EM_QUOT = 2'd3;

    typedef struct packed {
        logic               req_type;
        logic [3:0]         point_index;
        logic signed [15:0] point_x;
        logic signed [15:0] point_y;
        logic signed [15:0] query_x;
    } req_t;

    typedef struct packed {
        logic signed [15:0] curve_y;
        logic [2:0]         lookup_status;
    } rsp_t;

    typedef struct packed {
        logic       wr_en;
        logic       ld_query;
        logic       save_first;
        logic       save_prev;
        logic       mul_go;
        logic       div_go;
        logic       emit;
        logic [1:0] emit_sel;
        logic [2:0] emit_status;
    } cmd_t;

    typedef struct packed {
        logic le_first;
        logic ge_last;
        logic in_seg;
        logic dx_zero;
        logic div_done;
    } sts_t;

endpackage

### hdl/piecewise_linear_curve_lookup_top.sv
// Top level of the piecewise-linear curve lookup: controller plus datapath.
//
//  channel   signals                  direction  handshake
//  request   start, req (req_t)       in         taken when start & !busy
//  result    done, rsp (rsp_t)        out        one-cycle strobe on done
//  config    cfg_we, cfg_data         in         written when cfg_we is high
//
// A write request gives no result. A query is answered by a linear scan of the
// breakpoint memory, one point per cycle on its single read port, then a
// 33-step serial divider. busy is high from acceptance until the result cycle,
// but stays low for a query with fewer than two points in use.
// Reset clears the point count; table contents stay undefined until written.
module piecewise_linear_curve_lookup_top #(
    parameter int MAX_POINTS = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  plc_pkg::req_t req,
    output logic          done,
    output plc_pkg::rsp_t rsp,
    input  logic          cfg_we,
    input  logic [4:0]    cfg_data
);
    import plc_pkg::*;

    cmd_t                          cmd;
    sts_t                          sts;
    logic [$clog2(MAX_POINTS)-1:0] rd_addr;

    plc_ctrl #(
        .MAX_POINTS (MAX_POINTS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req_type (req.req_type),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .sts      (sts),
        .busy     (busy),
        .cmd      (cmd),
        .rd_addr  (rd_addr)
    );

    plc_dp #(
        .MAX_POINTS (MAX_POINTS)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .rd_addr (rd_addr),
        .req     (req),
        .sts     (sts),
        .done    (done),
        .rsp     (rsp)
    );

endmodule

### hdl/plc_div.sv
// Iterative restoring divider, one quotient bit per cycle.
module plc_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        go,
    input  logic [32:0] dividend,
    input  logic [16:0] divisor,
    output logic        done,
    output logic [16:0] quotient
);
    import plc_pkg::*;

    logic [DIV_W-1:0] quo_reg;
    logic [16:0]      rem_reg;
    logic [5:0]       cnt_reg;
    logic             run_reg;
    logic             done_reg;
    logic [16:0]      div_reg;
    logic [17:0]      trial;
    logic             fits;

    assign trial = {rem_reg[16:0], quo_reg[DIV_W-1]};
    assign fits  = trial >= {1'b0, div_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (go)
        begin
            run_reg  <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= 6'(DIV_W - 1);
        end
        else if (run_reg)
        begin
            if (cnt_reg == '0)
            begin
                run_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
            else
            begin
                cnt_reg <= cnt_reg - 6'd1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (run_reg)
        begin
            quo_reg <= {quo_reg[DIV_W-2:0], fits};
            rem_reg <= fits ? 17'(trial - {1'b0, div_reg}) : trial[16:0];
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg[16:0];

endmodule

### hdl/plc_dp.sv
// Datapath: breakpoint memories, compares, multiplier, divider and result register.
module plc_dp #(
    parameter int MAX_POINTS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  plc_pkg::cmd_t                 cmd,
    input  logic [$clog2(MAX_POINTS)-1:0] rd_addr,
    input  plc_pkg::req_t                 req,
    output plc_pkg::sts_t                 sts,
    output logic                          done,
    output plc_pkg::rsp_t                 rsp
);
    import plc_pkg::*;

    localparam int IDX_W = $clog2(MAX_POINTS);

    logic signed [15:0] x_mem [MAX_POINTS];
    logic signed [15:0] y_mem [MAX_POINTS];

    logic signed [15:0]     rd_x_reg;
    logic signed [15:0]     rd_y_reg;
    logic signed [15:0]     qx_reg;
    logic signed [15:0]     xl_reg;
    logic signed [15:0]     yl_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic [16:0]            dx_reg;
    logic                   neg_reg;
    logic                   done_reg;
    rsp_t                   rsp_reg;

    logic                   wr_ok;
    logic [IDX_W-1:0]       wr_addr;
    logic signed [DIFF_W-1:0] dy;
    logic signed [DIFF_W-1:0] dxq;
    logic signed [DIFF_W-1:0] dx;
    logic signed [PROD_W-1:0] prod_next;
    logic [DIV_W-1:0]       prod_mag;
    logic                   div_done;
    logic [16:0]            quo;
    logic signed [17:0]     quo_s;
    logic signed [17:0]     sum;
    logic signed [15:0]     sat_y;
    logic signed [15:0]     y_next;

    assign wr_ok   = 32'(req.point_index) < MAX_POINTS;
    assign wr_addr = IDX_W'(req.point_index);

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en && wr_ok)
        begin
            x_mem[wr_addr] <= req.point_x;
            y_mem[wr_addr] <= req.point_y;
        end
        rd_x_reg <= x_mem[rd_addr];
        rd_y_reg <= y_mem[rd_addr];
    end

    assign dy        = {rd_y_reg[15], rd_y_reg} - {yl_reg[15], yl_reg};
    assign dxq       = {qx_reg[15], qx_reg} - {xl_reg[15], xl_reg};
    assign dx        = {rd_x_reg[15], rd_x_reg} - {xl_reg[15], xl_reg};
    assign prod_next = dy * dxq;
    assign prod_mag  = prod_reg[PROD_W-1] ? DIV_W'(-prod_reg) : DIV_W'(prod_reg);

    assign sts.le_first = qx_reg <= rd_x_reg;
    assign sts.ge_last  = qx_reg >= rd_x_reg;
    assign sts.in_seg   = (qx_reg >= xl_reg) && (qx_reg <= rd_x_reg);
    assign sts.dx_zero  = rd_x_reg == xl_reg;
    assign sts.div_done = div_done;

    always_ff @(posedge clk)
    begin
        if (cmd.ld_query)
        begin
            qx_reg <= req.query_x;
        end
        if (cmd.save_first || cmd.save_prev)
        begin
            xl_reg <= rd_x_reg;
            yl_reg <= rd_y_reg;
        end
        if (cmd.mul_go)
        begin
            prod_reg <= prod_next;
            dx_reg   <= dx[16:0];
        end
        if (cmd.div_go)
        begin
            neg_reg <= prod_reg[PROD_W-1];
        end
    end

    plc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (cmd.div_go),
        .dividend (prod_mag),
        .divisor  (dx_reg),
        .done     (div_done),
        .quotient (quo)
    );

    assign quo_s = neg_reg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
    assign sum   = {{2{yl_reg[15]}}, yl_reg} + quo_s;

    always_comb
    begin
        if (sum > 18'sd32767)
            sat_y = 16'sh7fff;
        else if (sum < -18'sd32768)
            sat_y = 16'sh8000;
        else
            sat_y = sum[15:0];
    end

    always_comb
    begin
        case (cmd.emit_sel)
            EM_ZERO: y_next = '0;
            EM_RDY:  y_next = rd_y_reg;
            EM_YL:   y_next = yl_reg;
            EM_QUOT: y_next = sat_y;
            default: y_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= cmd.emit;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            rsp_reg.curve_y       <= y_next;
            rsp_reg.lookup_status <= cmd.emit_status;
        end
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

### hdl/plc_ctrl.sv
// Controller: request decode, segment scan sequencing and point-count register.
module plc_ctrl #(
    parameter int MAX_POINTS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          req_type,
    input  logic                          cfg_we,
    input  logic [4:0]                    cfg_data,
    input  plc_pkg::sts_t                 sts,
    output logic                          busy,
    output plc_pkg::cmd_t                 cmd,
    output logic [$clog2(MAX_POINTS)-1:0] rd_addr
);
    import plc_pkg::*;

    localparam int IDX_W = $clog2(MAX_POINTS);
    localparam int CNT_W = $clog2(MAX_POINTS + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHK0  = 3'd1;
    localparam logic [2:0] S_CHKL  = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_DIVGO = 3'd4;
    localparam logic [2:0] S_WAIT  = 3'd5;

    logic [2:0]       state_reg, state_next;
    logic [4:0]       active_points_reg;
    logic [CNT_W-1:0] n_reg, n_next;
    logic [CNT_W-1:0] i_reg, i_next;
    logic [CNT_W-1:0] n_clip;
    logic [CNT_W-1:0] last;
    logic [CNT_W-1:0] i_inc;

    assign n_clip = (32'(active_points_reg) > MAX_POINTS) ? CNT_W'(MAX_POINTS)
                                                          : CNT_W'(active_points_reg);
    assign last   = n_reg - CNT_W'(1);
    assign i_inc  = i_reg + CNT_W'(1);

    always_comb
    begin
        state_next = state_reg;
        n_next     = n_reg;
        i_next     = i_reg;
        cmd        = '0;
        rd_addr    = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (req_type == REQ_WRITE)
                    begin
                        cmd.wr_en = 1'b1;
                    end
                    else if (n_clip < CNT_W'(2))
                    begin
                        cmd.emit        = 1'b1;
                        cmd.emit_sel    = EM_ZERO;
                        cmd.emit_status = ST_FEW;
                    end
                    else
                    begin
                        cmd.ld_query = 1'b1;
                        n_next       = n_clip;
                        state_next   = S_CHK0;
                    end
                end
            end
            S_CHK0:
            begin
                if (sts.le_first)
                begin
                    cmd.emit        = 1'b1;
                    cmd.emit_sel    = EM_RDY;
                    cmd.emit_status = ST_BELOW;
                    state_next      = S_IDLE;
                end
                else
                begin
                    cmd.save_first = 1'b1;
                    rd_addr        = last[IDX_W-1:0];
                    state_next     = S_CHKL;
                end
            end
            S_CHKL:
            begin
                if (sts.ge_last)
                begin
                    cmd.emit        = 1'b1;
                    cmd.emit_sel    = EM_RDY;
                    cmd.emit_status = ST_ABOVE;
                    state_next      = S_IDLE;
                end
                else
                begin
                    rd_addr    = IDX_W'(1);
                    i_next     = CNT_W'(1);
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (sts.in_seg)
                begin
                    if (sts.dx_zero)
                    begin
                        cmd.emit        = 1'b1;
                        cmd.emit_sel    = EM_YL;
                        cmd.emit_status = ST_INTERP;
                        state_next      = S_IDLE;
                    end
                    else
                    begin
                        cmd.mul_go = 1'b1;
                        state_next = S_DIVGO;
                    end
                end
                else if (i_reg == last)
                begin
                    cmd.emit        = 1'b1;
                    cmd.emit_sel    = EM_ZERO;
                    cmd.emit_status = ST_NOSEG;
                    state_next      = S_IDLE;
                end
                else
                begin
                    cmd.save_prev = 1'b1;
                    rd_addr       = i_inc[IDX_W-1:0];
                    i_next        = i_inc;
                end
            end
            S_DIVGO:
            begin
                cmd.div_go = 1'b1;
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (sts.div_done)
                begin
                    cmd.emit        = 1'b1;
                    cmd.emit_sel    = EM_QUOT;
                    cmd.emit_status = ST_INTERP;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            active_points_reg <= '0;
            n_reg             <= '0;
            i_reg             <= '0;
        end
        else
        begin
            state_reg <= state_next;
            n_reg     <= n_next;
            i_reg     <= i_next;
            if (cfg_we)
            begin
                active_points_reg <= cfg_data;
            end
        end
    end

    assign busy = state_reg != S_IDLE;

endmodule

### tb/tb_piecewise_linear_curve_lookup_top.sv
// Self-checking testbench for the piecewise-linear curve lookup: directed table, then random.
module tb_piecewise_linear_curve_lookup_top;

    import plc_pkg::*;

    localparam int MAX_PTS       = 16;
    localparam int SETTLE_CYCLES = 64;
    localparam int STALL_LIMIT   = 2000;
    localparam int DIR_ROWS      = 25;
    localparam int PHASES        = 12;
    localparam int PHASE_ITEMS   = 125;

    localparam int ROW_CFG = 0;
    localparam int ROW_WR  = 1;
    localparam int ROW_QRY = 2;
    localparam int ROW_CHK = 3;

    logic       clk      = 1'b0;
    logic       rst_n    = 1'b0;
    logic       start    = 1'b0;
    req_t       req      = '0;
    logic       cfg_we   = 1'b0;
    logic [4:0] cfg_data = '0;
    logic       busy;
    logic       done;
    rsp_t       rsp;

    logic signed [15:0] bp_x [MAX_PTS];
    logic signed [15:0] bp_y [MAX_PTS];
    logic [4:0]         pts_in_use = '0;
    rsp_t               pending_lookups [$];
    rsp_t               want;
    int                 err_count    = 0;
    int                 quiet_cycles = 0;
    int                 burst_left   = 0;

    // kind, then point index / active points / query x, then x or expected y, then y or status
    int dir_plan [DIR_ROWS][4] = '{
        '{ROW_CHK, 0, 0, ST_FEW},
        '{ROW_CFG, 1, 0, 0},
        '{ROW_WR, 0, -32768, 32767},
        '{ROW_CHK, -32768, 0, ST_FEW},
        '{ROW_CFG, 3, 0, 0},
        '{ROW_WR, 1, 0, -32768},
        '{ROW_WR, 2, 32767, 32767},
        '{ROW_CHK, -32768, 32767, ST_BELOW},
        '{ROW_CHK, 32767, 32767, ST_ABOVE},
        '{ROW_QRY, -1, 0, 0},
        '{ROW_QRY, 0, 0, 0},
        '{ROW_QRY, 1, 0, 0},
        '{ROW_QRY, 16384, 0, 0},
        '{ROW_CFG, 4, 0, 0},
        '{ROW_WR, 0, -256, 0},
        '{ROW_WR, 1, 256, 256},
        '{ROW_WR, 2, 256, -256},
        '{ROW_WR, 3, 512, 512},
        '{ROW_QRY, 256, 0, 0},
        '{ROW_QRY, 300, 0, 0},
        '{ROW_CHK, -256, 0, ST_BELOW},
        '{ROW_CHK, 512, 512, ST_ABOVE},
        '{ROW_WR, 2, -1000, 77},
        '{ROW_QRY, 0, 0, 0},
        '{ROW_QRY, 400, 0, 0}
    };

    logic [4:0] phase_pts [PHASES] = '{2, 16, 31, 0, 16, 3, 1, 17, 9, 16, 2, 16};

    piecewise_linear_curve_lookup_top #(
        .MAX_POINTS(MAX_PTS)
    ) i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .req     (req),
        .done    (done),
        .rsp     (rsp),
        .cfg_we  (cfg_we),
        .cfg_data(cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        err_count++;
    endtask

    function automatic rsp_t lookup_curve(input logic signed [15:0] qx);
        rsp_t   res;
        int     n;
        bit     hit;
        longint dx;
        longint num;
        longint yv;
        res.curve_y       = '0;
        res.lookup_status = ST_NOSEG;
        hit               = 1'b0;
        n = (pts_in_use > 5'd16) ? MAX_PTS : int'(pts_in_use);
        if (n < 2)
            res.lookup_status = ST_FEW;
        else if (qx <= bp_x[0])
        begin
            res.curve_y       = bp_y[0];
            res.lookup_status = ST_BELOW;
        end
        else if (qx >= bp_x[n-1])
        begin
            res.curve_y       = bp_y[n-1];
            res.lookup_status = ST_ABOVE;
        end
        else
        begin
            for (int i = 0; i + 1 < n; i++)
            begin
                if (!hit && qx >= bp_x[i] && qx <= bp_x[i+1])
                begin
                    hit               = 1'b1;
                    res.lookup_status = ST_INTERP;
                    dx = longint'(bp_x[i+1]) - longint'(bp_x[i]);
                    if (dx == 0)
                        res.curve_y = bp_y[i];
                    else
                    begin
                        num = (longint'(bp_y[i+1]) - longint'(bp_y[i]))
                            * (longint'(qx) - longint'(bp_x[i]));
                        yv  = longint'(bp_y[i]) + num / dx;
                        if (yv > 32767)
                            res.curve_y = 16'sh7fff;
                        else if (yv < -32768)
                            res.curve_y = 16'sh8000;
                        else
                            res.curve_y = yv[15:0];
                    end
                end
            end
        end
        return res;
    endfunction

    function automatic req_t noise_req();
        req_t r;
        r.req_type    = 1'($urandom);
        r.point_index = 4'($urandom);
        r.point_x     = 16'($urandom);
        r.point_y     = 16'($urandom);
        r.query_x     = 16'($urandom);
        return r;
    endfunction

    task automatic pace_sender();
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 50));
            burst_left = ($urandom_range(0, 4) == 0) ? int'($urandom_range(50, 200))
                                                     : int'($urandom_range(1, 12));
            if (gap > 0)
            begin
                @(negedge clk);
                start <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
    endtask

    task automatic issue(input req_t r, input bit typed, input rsp_t typed_rsp);
        @(negedge clk);
        start <= 1'b1;
        req   <= r;
        do @(posedge clk); while (busy);
        if (r.req_type == REQ_QUERY)
            pending_lookups.push_back(typed ? typed_rsp : lookup_curve(r.query_x));
        else
        begin
            bp_x[r.point_index] = r.point_x;
            bp_y[r.point_index] = r.point_y;
        end
    endtask

    task automatic drain_block();
        @(negedge clk);
        start <= 1'b0;
        while (pending_lookups.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_active_points(input logic [4:0] v);
        drain_block();
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(negedge clk);
        cfg_we   <= 1'b0;
        cfg_data <= 5'($urandom);
        pts_in_use = v;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_lookups.size() == 0)
                report_mismatch("result with no query waiting");
            else
            begin
                want = pending_lookups.pop_front();
                if (rsp.curve_y !== want.curve_y)
                    report_mismatch($sformatf("curve_y %0d, want %0d",
                                              rsp.curve_y, want.curve_y));
                if (rsp.lookup_status !== want.lookup_status)
                    report_mismatch($sformatf("lookup_status %0d, want %0d",
                                              rsp.lookup_status, want.lookup_status));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || cfg_we)
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        req_t r;
        rsp_t fx;
        int   row;
        int   ph;
        int   k;
        int   shape;
        int   xv;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (row = 0; row < DIR_ROWS; row++)
        begin
            r = noise_req();
            case (dir_plan[row][0])
                ROW_CFG:
                    set_active_points(5'(dir_plan[row][1]));
                ROW_WR:
                begin
                    r.req_type    = REQ_WRITE;
                    r.point_index = 4'(dir_plan[row][1]);
                    r.point_x     = 16'(dir_plan[row][2]);
                    r.point_y     = 16'(dir_plan[row][3]);
                    pace_sender();
                    issue(r, 1'b0, '0);
                end
                default:
                begin
                    r.req_type       = REQ_QUERY;
                    r.query_x        = 16'(dir_plan[row][1]);
                    fx.curve_y       = 16'(dir_plan[row][2]);
                    fx.lookup_status = 3'(dir_plan[row][3]);
                    pace_sender();
                    issue(r, dir_plan[row][0] == ROW_CHK, fx);
                end
            endcase
        end

        for (ph = 0; ph < PHASES; ph++)
        begin
            set_active_points(phase_pts[ph]);
            // reload every point: mostly sorted, sometimes crowded, now and then scrambled
            shape = $urandom_range(0, 9);
            xv    = -32768 + int'($urandom_range(0, 2000));
            for (k = 0; k < MAX_PTS; k++)
            begin
                r             = noise_req();
                r.req_type    = REQ_WRITE;
                r.point_index = 4'(k);
                if (shape != 9)
                begin
                    r.point_x = 16'(xv);
                    xv += (shape >= 7) ? int'($urandom_range(0, 3))
                                       : int'($urandom_range(0, 3900));
                end
                pace_sender();
                issue(r, 1'b0, '0);
            end
            for (k = 0; k < PHASE_ITEMS; k++)
            begin
                r = noise_req();
                if ($urandom_range(0, 99) < 85)
                begin
                    r.req_type = REQ_QUERY;
                    case ($urandom_range(0, 3))
                        0: ;
                        1: r.query_x = bp_x[4'($urandom)] + 16'($urandom_range(0, 8)) - 16'sd4;
                        2: r.query_x = bp_x[4'($urandom)] + 16'($urandom_range(0, 4095));
                        default: r.query_x = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
                    endcase
                end
                else
                    r.req_type = REQ_WRITE;
                pace_sender();
                issue(r, 1'b0, '0);
            end
        end

        drain_block();
        if (err_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
